>>> sv/vau_pkg.sv
// Package for the eight-lane vector unit: lane, accumulator and channel payload types,
// function and transfer codes, lane flag struct, and build-time reciprocal/root table.
// Depends on nothing; vau_lane and eight_lane_vector_alu import it.
package vau_pkg;

  localparam int LANES     = 8;
  localparam int VREGS     = 32;
  localparam int ROM_DEPTH = 1024;

  typedef logic [15:0] lane_t;
  typedef logic [47:0] acc_t;
  typedef logic [5:0]  func_t;
  typedef logic [4:0]  subop_t;
  typedef lane_t       rom_t [ROM_DEPTH];

  // Vector function codes (instruction bits 5:0).
  localparam func_t FN_VMULF = 6'h00;
  localparam func_t FN_VMULU = 6'h01;
  localparam func_t FN_VRNDP = 6'h02;
  localparam func_t FN_VMULQ = 6'h03;
  localparam func_t FN_VMUDL = 6'h04;
  localparam func_t FN_VMUDM = 6'h05;
  localparam func_t FN_VMUDN = 6'h06;
  localparam func_t FN_VMUDH = 6'h07;
  localparam func_t FN_VMACF = 6'h08;
  localparam func_t FN_VMACU = 6'h09;
  localparam func_t FN_VRNDN = 6'h0A;
  localparam func_t FN_VMACQ = 6'h0B;
  localparam func_t FN_VMADL = 6'h0C;
  localparam func_t FN_VMADM = 6'h0D;
  localparam func_t FN_VMADN = 6'h0E;
  localparam func_t FN_VMADH = 6'h0F;
  localparam func_t FN_VADD  = 6'h10;
  localparam func_t FN_VSUB  = 6'h11;
  localparam func_t FN_RSV12 = 6'h12;
  localparam func_t FN_VABS  = 6'h13;
  localparam func_t FN_VADDC = 6'h14;
  localparam func_t FN_VSUBC = 6'h15;
  localparam func_t FN_RSV16 = 6'h16;
  localparam func_t FN_RSV1C = 6'h1C;
  localparam func_t FN_VSAR  = 6'h1D;
  localparam func_t FN_RSV1E = 6'h1E;
  localparam func_t FN_RSV1F = 6'h1F;
  localparam func_t FN_VLT   = 6'h20;
  localparam func_t FN_VEQ   = 6'h21;
  localparam func_t FN_VNE   = 6'h22;
  localparam func_t FN_VGE   = 6'h23;
  localparam func_t FN_VCL   = 6'h24;
  localparam func_t FN_VCH   = 6'h25;
  localparam func_t FN_VCR   = 6'h26;
  localparam func_t FN_VMRG  = 6'h27;
  localparam func_t FN_VAND  = 6'h28;
  localparam func_t FN_VNAND = 6'h29;
  localparam func_t FN_VOR   = 6'h2A;
  localparam func_t FN_VNOR  = 6'h2B;
  localparam func_t FN_VXOR  = 6'h2C;
  localparam func_t FN_VNXOR = 6'h2D;
  localparam func_t FN_RSV2E = 6'h2E;
  localparam func_t FN_RSV2F = 6'h2F;
  localparam func_t FN_VRCP  = 6'h30;
  localparam func_t FN_VRCPL = 6'h31;
  localparam func_t FN_VRCPH = 6'h32;
  localparam func_t FN_VMOV  = 6'h33;
  localparam func_t FN_VRSQ  = 6'h34;
  localparam func_t FN_VRSQL = 6'h35;
  localparam func_t FN_VRSQH = 6'h36;
  localparam func_t FN_VNOP  = 6'h37;
  localparam func_t FN_RSV38 = 6'h38;
  localparam func_t FN_RSV3F = 6'h3F;

  // Transfer subops (instruction bits 25:21 with bit 25 clear).
  localparam subop_t SUB_MFC   = 5'h00;
  localparam subop_t SUB_RSV01 = 5'h01;
  localparam subop_t SUB_CFC   = 5'h02;
  localparam subop_t SUB_MTC   = 5'h04;
  localparam subop_t SUB_CTC   = 5'h06;

  // Control register select (rd bits 1:0).
  localparam logic [1:0] CSEL_CARRY   = 2'd0;
  localparam logic [1:0] CSEL_COMPARE = 2'd1;

  typedef struct packed {
    logic [31:0] instruction_word;
    logic [15:0] scalar_in;
  } cmd_t;

  typedef struct packed {
    logic [31:0] scalar_out;
    logic        scalar_write;
    logic [4:0]  scalar_index;
    logic        reserved_code;
  } rsp_t;

  // Per-lane view of the flag registers.
  typedef struct packed {
    logic carry;
    logic not_equal;
    logic cmp_lo;
    logic cmp_hi;
    logic ext;
  } lane_flags_t;

  // Source lane for the vt operand under element modifier e.
  function automatic logic [2:0] elem_sel(logic [3:0] e, logic [2:0] lane);
    logic [2:0] idx;
    if (e[3]) begin
      idx = e[2:0];
    end else if (e[2]) begin
      idx = {lane[2], e[1:0]};
    end else if (e[1]) begin
      idx = {lane[2:1], e[0]};
    end else begin
      idx = lane;
    end
    return idx;
  endfunction

  // Saturate a 32-bit two's complement value to 16 bits.
  function automatic lane_t clamp32(logic [31:0] v);
    lane_t res;
    if (!v[31] && (v[30:15] != '0)) begin
      res = 16'h7FFF;
    end else if (v[31] && (v[30:15] != '1)) begin
      res = 16'h8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // Shift-subtract divider, used only while building the table.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], n[k]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // Integer square root, used only while building the table.
  function automatic logic [31:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'h1 << 62;
    x = v;
    for (int k = 0; k < 32; k++) begin
      if (b > x) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != '0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r[31:0];
  endfunction

  // One table entry: reciprocal in the low half, inverse root in the high half.
  function automatic lane_t rom_value(int unsigned addr);
    logic [63:0] full;
    int unsigned idx;
    int unsigned ex;
    if (addr < 512) begin
      full = udiv64(64'h1 << 26, 64'(addr + 512));
    end else begin
      idx  = addr - 512;
      ex   = (idx % 2 == 1) ? 42 : 41;
      full = 64'(isqrt64(udiv64(64'h1 << ex, 64'(idx / 2 + 256))));
    end
    if (full > 64'h1FFFF) full = 64'h1FFFF;
    return full[15:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t tbl;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      tbl[k] = rom_value(k);
    end
    return tbl;
  endfunction

endpackage

>>> sv/vau_stream_if.sv
// Valid/ready channel used for the instruction and result streams of the vector unit.
// The payload type is set per instance; the block uses the structs of vau_pkg.
interface vau_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/vau_lane.sv
// One 16-bit lane of the vector unit: multiply/accumulate, add, compare, clip and logic.
// Depends on vau_pkg for types, function codes and the saturation helper.
module vau_lane (
  input  vau_pkg::func_t       fn,
  input  logic                 vs_odd,
  input  vau_pkg::lane_t       s,
  input  vau_pkg::lane_t       t,
  input  vau_pkg::acc_t        acc,
  input  vau_pkg::lane_flags_t flags,
  output vau_pkg::lane_t       r,
  output vau_pkg::acc_t        acc_next,
  output vau_pkg::lane_flags_t flags_next
);
  import vau_pkg::*;

  logic               use_us;
  logic               use_ut;
  logic signed [16:0] op_a;
  logic signed [16:0] op_b;
  logic signed [33:0] prod;
  logic [47:0]        p48;
  logic [47:0]        addend;
  logic [47:0]        sum;
  logic [31:0]        mid;
  logic [47:0]        rnd_val;
  logic               rnd_add;
  logic [31:0]        q32;
  logic [31:0]        ub;
  logic [17:0]        sat_sum;
  logic [16:0]        sum17;
  logic [16:0]        diff17;
  logic               c_in;
  logic               eq_st;
  logic               k;
  lane_t              ab;
  lane_t              adj0;
  lane_t              adj;
  lane_t              dd;
  lane_t              msk;
  logic               sg;
  logic               corner;
  logic               ext_hit;
  logic               el;
  logic               lo;
  logic               hi;

  // Shared 17x17 signed multiplier; operand signedness follows the function.
  always_comb begin
    use_us = fn inside {FN_VMUDL, FN_VMADL, FN_VMUDN, FN_VMADN};
    use_ut = fn inside {FN_VMUDL, FN_VMADL, FN_VMUDM, FN_VMADM};
    op_a   = use_us ? {1'b0, s} : {s[15], s};
    op_b   = use_ut ? {1'b0, t} : {t[15], t};
    prod   = op_a * op_b;
    p48    = {{14{prod[33]}}, prod};
  end

  // Lane result, accumulator and flags.
  always_comb begin
    r          = '0;
    acc_next   = acc;
    flags_next = flags;
    addend     = '0;
    sum        = '0;
    mid        = '0;
    rnd_val    = '0;
    rnd_add    = 1'b0;
    q32        = '0;
    ub         = '0;
    c_in       = flags.carry;
    sat_sum    = '0;
    sum17      = {1'b0, s} + {1'b0, t};
    diff17     = {1'b0, s} - {1'b0, t};
    eq_st      = (s == t);
    k          = 1'b0;
    ab         = '0;
    adj0       = '0;
    adj        = '0;
    dd         = '0;
    msk        = '0;
    sg         = s[15] ^ t[15];
    corner     = (t == 16'h8000);
    ext_hit    = 1'b0;
    el         = 1'b0;
    lo         = 1'b0;
    hi         = 1'b0;

    case (fn)
      FN_VRNDP, FN_VRNDN: begin
        rnd_val  = vs_odd ? {{16{t[15]}}, t, 16'h0000} : {{32{t[15]}}, t};
        rnd_add  = (fn == FN_VRNDP) ? !acc[47] : acc[47];
        acc_next = rnd_add ? acc + rnd_val : acc;
        r        = clamp32(acc_next[47:16]);
      end
      FN_VMULQ: begin
        q32      = prod[33] ? prod[31:0] + 32'd31 : prod[31:0];
        acc_next = {q32, 16'h0000};
        r        = clamp32({q32[31], q32[31:1]}) & 16'hFFF0;
      end
      FN_VMACQ: begin
        ub = acc[47:16];
        if (!ub[5]) begin
          if (ub[31] && (ub < 32'hFFFF_FFE0)) begin
            ub = ub + 32'h20;
          end else if (!ub[31] && (ub > 32'h20)) begin
            ub = ub - 32'h20;
          end
        end
        acc_next = {ub, acc[15:0]};
        r        = clamp32({ub[31], ub[31:1]}) & 16'hFFF0;
      end
      FN_VMULF, FN_VMULU, FN_VMUDL, FN_VMUDM, FN_VMUDN, FN_VMUDH,
      FN_VMACF, FN_VMACU, FN_VMADL, FN_VMADM, FN_VMADN, FN_VMADH: begin
        case (fn)
          FN_VMULF, FN_VMULU: addend = {p48[46:0], 1'b0} + 48'h8000;
          FN_VMACF, FN_VMACU: addend = {p48[46:0], 1'b0};
          FN_VMUDL, FN_VMADL: addend = {32'h0, prod[31:16]};
          FN_VMUDH, FN_VMADH: addend = {p48[31:0], 16'h0000};
          default:            addend = p48;
        endcase
        sum      = (fn[3] ? acc : '0) + addend;
        acc_next = sum;
        mid      = sum[47:16];
        if (fn == FN_VMULU || fn == FN_VMACU) begin
          if (mid[31]) r = '0;
          else if (mid[30:16] != '0) r = 16'hFFFF;
          else r = mid[15:0];
        end else if (fn inside {FN_VMUDL, FN_VMUDN, FN_VMADL, FN_VMADN}) begin
          if (!mid[31] && (mid[30:15] != '0)) r = 16'hFFFF;
          else if (mid[31] && (mid[30:15] != '1)) r = '0;
          else r = sum[15:0];
        end else begin
          r = clamp32(mid);
        end
      end
      FN_VADD, FN_VSUB: begin
        if (fn == FN_VADD) begin
          sat_sum = {{2{s[15]}}, s} + {{2{t[15]}}, t} + {17'h0, c_in};
        end else begin
          sat_sum = {{2{s[15]}}, s} - {{2{t[15]}}, t} - {17'h0, c_in};
        end
        r                    = clamp32({{14{sat_sum[17]}}, sat_sum});
        acc_next             = {acc[47:16], r};
        flags_next.carry     = 1'b0;
        flags_next.not_equal = 1'b0;
      end
      FN_VABS: begin
        if (s == '0) r = '0;
        else if (!s[15]) r = t;
        else if (corner) r = 16'h7FFF;
        else r = 16'(-t);
        acc_next = {acc[47:16], r};
      end
      FN_VADDC: begin
        r                    = sum17[15:0];
        acc_next             = {acc[47:16], r};
        flags_next.carry     = sum17[16];
        flags_next.not_equal = 1'b0;
      end
      FN_VSUBC: begin
        r                    = diff17[15:0];
        acc_next             = {acc[47:16], r};
        flags_next.carry     = diff17[16];
        flags_next.not_equal = !eq_st;
      end
      FN_VLT, FN_VEQ, FN_VNE, FN_VGE: begin
        case (fn)
          FN_VLT:  k = ($signed(s) < $signed(t)) || (eq_st && flags.not_equal && flags.carry);
          FN_VEQ:  k = eq_st && !flags.not_equal;
          FN_VNE:  k = !eq_st || flags.not_equal;
          default: k = ($signed(s) > $signed(t))
                       || (eq_st && !(flags.not_equal && flags.carry));
        endcase
        r                    = k ? s : t;
        acc_next             = {acc[47:16], r};
        flags_next.cmp_lo    = k;
        flags_next.cmp_hi    = 1'b0;
        flags_next.carry     = 1'b0;
        flags_next.not_equal = 1'b0;
        flags_next.ext       = 1'b0;
      end
      FN_VCL: begin
        ab = flags.carry ? 16'(-t) : t;
        el = flags.ext ? ((s == ab) || !sum17[16]) : ((s == ab) && !sum17[16]);
        lo = (!flags.not_equal && flags.carry) ? el : flags.cmp_lo;
        hi = (!flags.not_equal && !flags.carry) ? (s >= ab) : flags.cmp_hi;
        r                    = (flags.carry ? lo : hi) ? ab : s;
        acc_next             = {acc[47:16], r};
        flags_next.cmp_lo    = lo;
        flags_next.cmp_hi    = hi;
        flags_next.carry     = 1'b0;
        flags_next.not_equal = 1'b0;
        flags_next.ext       = 1'b0;
      end
      FN_VCH: begin
        adj0    = sg ? ~t : t;
        ext_hit = sg && (s == adj0);
        adj     = (sg && !corner) ? adj0 + 16'd1 : adj0;
        dd      = adj - s;
        lo      = sg ? !dd[15] : t[15];
        hi      = sg ? t[15] : ($signed(s) >= $signed(t));
        r                    = (sg ? lo : hi) ? adj : s;
        acc_next             = {acc[47:16], r};
        flags_next.cmp_lo    = lo;
        flags_next.cmp_hi    = hi;
        flags_next.carry     = sg;
        flags_next.not_equal = !(((s == adj) && !corner) || ext_hit);
        flags_next.ext       = ext_hit;
      end
      FN_VCR: begin
        msk = {16{sg}};
        lo  = $signed(t) <= $signed(~(s & msk));
        hi  = $signed(s | msk) >= $signed(t);
        r                    = (sg ? lo : hi) ? (t ^ msk) : s;
        acc_next             = {acc[47:16], r};
        flags_next.cmp_lo    = lo;
        flags_next.cmp_hi    = hi;
        flags_next.carry     = 1'b0;
        flags_next.not_equal = 1'b0;
        flags_next.ext       = 1'b0;
      end
      FN_VMRG, FN_VAND, FN_VNAND, FN_VOR, FN_VNOR, FN_VXOR, FN_VNXOR: begin
        case (fn)
          FN_VMRG:  r = flags.cmp_lo ? s : t;
          FN_VAND:  r = s & t;
          FN_VNAND: r = ~(s & t);
          FN_VOR:   r = s | t;
          FN_VNOR:  r = ~(s | t);
          FN_VXOR:  r = s ^ t;
          default:  r = ~(s ^ t);
        endcase
        acc_next = {acc[47:16], r};
      end
      FN_VRCP, FN_VRCPL, FN_VRCPH, FN_VMOV, FN_VRSQ, FN_VRSQL, FN_VRSQH: begin
        // Moves and estimates load the low accumulator slice with the vt operand.
        r        = t;
        acc_next = {acc[47:16], t};
      end
      default: begin
        r = '0;
      end
    endcase
  end

endmodule

>>> sv/eight_lane_vector_alu.sv
// Eight-lane 16-bit vector unit. Each transfer on cmd carries one coprocessor instruction
// and the scalar operand; each transfer on rsp returns its one result. An instruction passes
// through the input register, then one execute pass into the result register. A new one
// is taken every cycle while rsp is not stalled: the register file, accumulators and flags
// are written at the same edge that loads the result, so the next instruction already sees
// them. The reciprocal and inverse root table is built at elaboration. No clearing pass.
// Depends on vau_pkg, vau_stream_if and vau_lane.
module eight_lane_vector_alu (
  input logic          clk,
  input logic          rst,
  vau_stream_if.sink   cmd,
  vau_stream_if.source rsp
);
  import vau_pkg::*;

  localparam rom_t RECIP_ROM = build_rom();

  // Architectural state.
  lane_t       vfile [VREGS][LANES];
  acc_t        accs [LANES];
  logic [15:0] cne;
  logic [15:0] cmp;
  logic [7:0]  ext;
  logic [31:0] div_in;
  logic [31:0] div_out;
  logic        div_pend;

  // Pipeline registers.
  logic stage_valid;
  cmd_t stage;
  logic out_valid;
  rsp_t out_data;
  logic advance;

  // Decoded fields.
  logic [31:0] w;
  subop_t      sub;
  func_t       fn;
  logic [3:0]  e;
  logic [4:0]  vt;
  logic [4:0]  vs;
  logic [4:0]  vd;
  logic [3:0]  el;
  logic [2:0]  dl;
  logic        is_vec;
  logic        fn_rsv;

  // Operands and lane outputs.
  lane_t       s_op [LANES];
  lane_t       t_op [LANES];
  lane_t       d_op [LANES];
  lane_t       ib;
  lane_t       lane_r [LANES];
  acc_t        lane_acc [LANES];
  lane_flags_t lane_fin [LANES];
  lane_flags_t lane_fout [LANES];
  logic [7:0]  rd_bytes [16];

  // Estimate path.
  logic        est_root;
  logic [31:0] est_src;
  logic        est_neg;
  logic [31:0] est_mag;
  logic [4:0]  est_shift;
  logic [31:0] est_norm;
  logic [9:0]  est_addr;
  logic [4:0]  est_osh;
  logic [31:0] est_out;

  // Next state and result.
  logic        vwe;
  logic [4:0]  widx;
  lane_t       wr_data [LANES];
  acc_t        accs_next [LANES];
  logic [15:0] cne_next;
  logic [15:0] cmp_next;
  logic [7:0]  ext_next;
  logic [31:0] div_in_next;
  logic [31:0] div_out_next;
  logic        div_pend_next;
  logic [15:0] val;
  logic        s_wr;
  logic        rsv;

  // Handshake: the input register moves on whenever the result register can take it.
  assign advance   = stage_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !stage_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.ready) stage_valid <= cmd.valid;
      if (advance) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) stage <= cmd.data;
  end

  // Instruction decode.
  always_comb begin
    w      = stage.instruction_word;
    sub    = w[25:21];
    fn     = w[5:0];
    e      = w[24:21];
    vt     = w[20:16];
    vs     = w[15:11];
    vd     = w[10:6];
    el     = w[10:7];
    dl     = vs[2:0];
    is_vec = sub[4];
    fn_rsv = (fn == FN_RSV12) || ((fn >= FN_RSV16) && (fn <= FN_RSV1C))
             || (fn == FN_RSV1E) || (fn == FN_RSV1F)
             || (fn == FN_RSV2E) || (fn == FN_RSV2F)
             || ((fn >= FN_RSV38) && (fn <= FN_RSV3F));
  end

  // Register file reads and element selection.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      s_op[i]            = vfile[vs][i];
      t_op[i]            = vfile[vt][elem_sel(e, 3'(i))];
      d_op[i]            = vfile[vd][i];
      rd_bytes[2 * i]     = s_op[i][15:8];
      rd_bytes[2 * i + 1] = s_op[i][7:0];
    end
    ib = vfile[vt][e[2:0]];
  end

  // Lane datapaths.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    assign lane_fin[g].carry     = cne[g];
    assign lane_fin[g].not_equal = cne[g + LANES];
    assign lane_fin[g].cmp_lo    = cmp[g];
    assign lane_fin[g].cmp_hi    = cmp[g + LANES];
    assign lane_fin[g].ext       = ext[g];

    vau_lane u_lane (
      .fn         (fn),
      .vs_odd     (vs[0]),
      .s          (s_op[g]),
      .t          (t_op[g]),
      .acc        (accs[g]),
      .flags      (lane_fin[g]),
      .r          (lane_r[g]),
      .acc_next   (lane_acc[g]),
      .flags_next (lane_fout[g])
    );
  end

  // Reciprocal and inverse square root estimate.
  always_comb begin
    est_root = (fn == FN_VRSQ) || (fn == FN_VRSQL);
    if ((fn == FN_VRCPL || fn == FN_VRSQL) && div_pend) begin
      est_src = div_in | {16'h0000, ib};
    end else begin
      est_src = {{16{ib[15]}}, ib};
    end
    est_neg = est_src[31];
    if (!div_pend || !est_neg) begin
      est_mag = est_neg ? 32'(-est_src) : est_src;
    end else begin
      est_mag = (est_src >= 32'hFFFF_8000) ? 32'(-est_src) : ~est_src;
    end
    // Leading zero count; the highest set bit wins.
    est_shift = div_pend ? 5'd0 : 5'd16;
    for (int k = 0; k < 32; k++) begin
      if (est_mag[k]) est_shift = 5'(31 - k);
    end
    est_norm = est_mag << est_shift;
    est_addr = {1'b0, est_norm[30:22]};
    if (est_root) est_addr = {1'b1, est_norm[30:23], est_shift[0]};
    est_osh = est_shift ^ 5'd31;
    if (est_root) est_osh = est_osh >> 1;
    est_out = (32'h4000_0000 | ({16'h0000, RECIP_ROM[est_addr]} << 14)) >> est_osh;
    if (est_src == '0) est_out = 32'h7FFF_FFFF;
    else if (est_src == 32'hFFFF_8000) est_out = 32'hFFFF_0000;
    else if (est_neg) est_out = ~est_out;
  end

  // Execute: next state and result for the instruction in the input register.
  always_comb begin
    vwe           = 1'b0;
    widx          = vd;
    wr_data       = lane_r;
    accs_next     = accs;
    cne_next      = cne;
    cmp_next      = cmp;
    ext_next      = ext;
    div_in_next   = div_in;
    div_out_next  = div_out;
    div_pend_next = div_pend;
    val           = '0;
    s_wr          = 1'b0;
    rsv           = 1'b0;

    if (is_vec) begin
      if (fn_rsv) begin
        rsv = 1'b1;
      end else if (fn == FN_VNOP) begin
        vwe = 1'b0;
      end else if (fn == FN_VSAR) begin
        // Accumulator read: high, middle or low slice, zeros for other modifiers.
        vwe = 1'b1;
        for (int i = 0; i < LANES; i++) begin
          case (e)
            4'd8:    wr_data[i] = accs[i][47:32];
            4'd9:    wr_data[i] = accs[i][31:16];
            4'd10:   wr_data[i] = accs[i][15:0];
            default: wr_data[i] = '0;
          endcase
        end
      end else begin
        vwe       = 1'b1;
        accs_next = lane_acc;
        for (int i = 0; i < LANES; i++) begin
          cne_next[i]         = lane_fout[i].carry;
          cne_next[i + LANES] = lane_fout[i].not_equal;
          cmp_next[i]         = lane_fout[i].cmp_lo;
          cmp_next[i + LANES] = lane_fout[i].cmp_hi;
          ext_next[i]         = lane_fout[i].ext;
        end
        if (fn >= FN_VRCP) begin
          // Moves and estimates change one lane of vd.
          wr_data = d_op;
          case (fn)
            FN_VMOV: begin
              wr_data[dl] = t_op[dl];
            end
            FN_VRCPH, FN_VRSQH: begin
              wr_data[dl]   = div_out[31:16];
              div_in_next   = {ib, 16'h0000};
              div_pend_next = 1'b1;
            end
            default: begin
              div_in_next   = est_src;
              div_out_next  = est_out;
              wr_data[dl]   = est_out[15:0];
              div_pend_next = 1'b0;
            end
          endcase
        end
      end
    end else begin
      case (sub)
        SUB_MFC: begin
          val  = {rd_bytes[el], rd_bytes[4'(el + 4'd1)]};
          s_wr = 1'b1;
        end
        SUB_CFC: begin
          case (vs[1:0])
            CSEL_CARRY:   val = cne;
            CSEL_COMPARE: val = cmp;
            default:      val = {8'h00, ext};
          endcase
          s_wr = 1'b1;
        end
        SUB_MTC: begin
          // Byte write into rd; the second byte is dropped at element fifteen.
          vwe  = 1'b1;
          widx = vs;
          for (int i = 0; i < LANES; i++) begin
            for (int h = 0; h < 2; h++) begin
              if (4'(2 * i + h) == el) begin
                if (h == 0) wr_data[i][15:8] = stage.scalar_in[15:8];
                else wr_data[i][7:0] = stage.scalar_in[15:8];
              end else if (el != 4'd15 && 4'(2 * i + h) == 4'(el + 4'd1)) begin
                if (h == 0) wr_data[i][15:8] = stage.scalar_in[7:0];
                else wr_data[i][7:0] = stage.scalar_in[7:0];
              end else begin
                if (h == 0) wr_data[i][15:8] = s_op[i][15:8];
                else wr_data[i][7:0] = s_op[i][7:0];
              end
            end
          end
        end
        SUB_CTC: begin
          case (vs[1:0])
            CSEL_CARRY:   cne_next = stage.scalar_in;
            CSEL_COMPARE: cmp_next = stage.scalar_in;
            default:      ext_next = stage.scalar_in[7:0];
          endcase
        end
        default: begin
          rsv = 1'b1;
        end
      endcase
    end
  end

  // State and result update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < VREGS; j++) begin
        for (int i = 0; i < LANES; i++) begin
          vfile[j][i] <= '0;
        end
      end
      for (int i = 0; i < LANES; i++) begin
        accs[i] <= '0;
      end
      cne      <= '0;
      cmp      <= '0;
      ext      <= '0;
      div_in   <= '0;
      div_out  <= '0;
      div_pend <= 1'b0;
    end else if (advance) begin
      if (vwe) begin
        for (int i = 0; i < LANES; i++) begin
          vfile[widx][i] <= wr_data[i];
        end
      end
      accs     <= accs_next;
      cne      <= cne_next;
      cmp      <= cmp_next;
      ext      <= ext_next;
      div_in   <= div_in_next;
      div_out  <= div_out_next;
      div_pend <= div_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.scalar_out    <= s_wr ? {{16{val[15]}}, val} : '0;
      out_data.scalar_write  <= s_wr;
      out_data.scalar_index  <= s_wr ? vt : '0;
      out_data.reserved_code <= rsv;
    end
  end

  // A result never both writes a scalar register and reports a reserved code.
  a_write_not_reserved: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.data.scalar_write && rsp.data.reserved_code))
    else $error("result writes a scalar register for a reserved code");

  // Results without a scalar write carry zero value and index.
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.data.scalar_write)
      |-> (rsp.data.scalar_out == '0 && rsp.data.scalar_index == '0))
    else $error("non-writing result has nonzero scalar fields");

  // Back pressure on cmd only when both registers are full and rsp is stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (stage_valid && out_valid && !rsp.ready))
    else $error("cmd stalled without a full pipeline");

  // A new result only follows an instruction held in the input register.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(stage_valid))
    else $error("result appeared without an instruction");

  // A high-half estimate setup leaves the pending mark set.
  a_div_pending: assert property (@(posedge clk) disable iff (rst)
    (advance && is_vec && (fn == FN_VRCPH || fn == FN_VRSQH)) |=> div_pend)
    else $error("pending mark not set after high-half setup");

endmodule
